// File: rtl/separable_blur_5x5_stream_assert.svh
// ----------------------------------------------------------------------------
// separable blur assertion macros
// shared assertion shorthands for the blur checker
// ----------------------------------------------------------------------------
`ifndef SEPARABLE_BLUR_5X5_STREAM_ASSERT_SVH
`define SEPARABLE_BLUR_5X5_STREAM_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define SBLUR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sblur assertion failed");

// next-cycle implication, disabled while reset is held
`define SBLUR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sblur assertion failed");

`endif

// File: rtl/sblur_pkg.sv
// ----------------------------------------------------------------------------
// sblur_pkg
// constants, types and filter arithmetic shared by the blur modules
// ----------------------------------------------------------------------------
package sblur_pkg;

    // geometry
    localparam int MAX_WIDTH     = 2048;
    localparam int KERNEL_TAPS   = 5;
    localparam int KERNEL_HALF   = KERNEL_TAPS / 2;
    localparam int NUM_LINES     = KERNEL_TAPS - 1;
    localparam int CENTER_DEPTH  = KERNEL_HALF + 1;
    localparam int LINE_SEL_W    = $clog2(NUM_LINES);
    localparam int COL_W         = $clog2(MAX_WIDTH);

    // configuration
    localparam int CFG_W         = 12;
    localparam int CFG_IDX_W     = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam int WIDTH_MIN     = 5;
    localparam int HEIGHT_MIN    = 5;
    localparam int HEIGHT_MAX    = (1 << CFG_W) - 1;
    localparam int WIDTH_EFF_MAX = (MAX_WIDTH < HEIGHT_MAX) ? MAX_WIDTH : HEIGHT_MAX;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;

    // request kinds
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // counters
    localparam int ROW_W     = CFG_W + 1;
    localparam int COLX_W    = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int OUT_CNT_W = $clog2(WIDTH_EFF_MAX * HEIGHT_MAX + 1);

    // pixel arithmetic
    localparam int CHAN_W      = 8;
    localparam int SUM_W       = 12;
    localparam int DIV10_MUL   = 3277;
    localparam int DIV10_SHIFT = 15;
    localparam int DIV10_PROD_W = SUM_W + 12;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pix;

    // per-request control passed from the sequencer to the filter
    typedef struct packed {
        logic vert_en;
        logic center_en;
        logic emit;
        logic border;
        logic eof;
    } t_item_ctrl;

    // exact floor(s / 10) for s up to 2550
    function automatic logic [CHAN_W-1:0] div10(input logic [SUM_W-1:0] s);
        logic [DIV10_PROD_W-1:0] prod;
        prod = DIV10_PROD_W'(s) * DIV10_PROD_W'(DIV10_MUL);
        return prod[DIV10_SHIFT +: CHAN_W];
    endfunction

    // 1,2,4,2,1 weighted sum over ten, one channel
    function automatic logic [CHAN_W-1:0] mix5(
        input logic [CHAN_W-1:0] a,
        input logic [CHAN_W-1:0] b,
        input logic [CHAN_W-1:0] c,
        input logic [CHAN_W-1:0] d,
        input logic [CHAN_W-1:0] e
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + (SUM_W'(b) << 1) + (SUM_W'(c) << 2) + (SUM_W'(d) << 1) + SUM_W'(e);
        return div10(s);
    endfunction

    function automatic t_pix mix5_pix(
        input t_pix a,
        input t_pix b,
        input t_pix c,
        input t_pix d,
        input t_pix e
    );
        t_pix r;
        r.red   = mix5(a.red,   b.red,   c.red,   d.red,   e.red);
        r.green = mix5(a.green, b.green, c.green, d.green, e.green);
        r.blue  = mix5(a.blue,  b.blue,  c.blue,  d.blue,  e.blue);
        return r;
    endfunction

endpackage

// File: rtl/sblur_in_if.sv
// ----------------------------------------------------------------------------
// sblur_in_if
// input pixel channel: valid/ready handshake with pixel and flush flag
// ----------------------------------------------------------------------------
interface sblur_in_if import sblur_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [CHAN_W-1:0] in_blue;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_red;

    modport source (output valid, action, in_blue, in_green, in_red, input ready);
    modport sink   (input valid, action, in_blue, in_green, in_red, output ready);
endinterface

// File: rtl/sblur_out_if.sv
// ----------------------------------------------------------------------------
// sblur_out_if
// result pixel channel: valid/ready handshake with pixel and frame end flag
// ----------------------------------------------------------------------------
interface sblur_out_if import sblur_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_red;
    logic              end_of_frame;

    modport source (output valid, out_blue, out_green, out_red, end_of_frame, input ready);
    modport sink   (input valid, out_blue, out_green, out_red, end_of_frame, output ready);
endinterface

// File: rtl/sblur_ctrl.sv
// ----------------------------------------------------------------------------
// sblur_ctrl
// frame size registers, stream position counters and per-request control
// ----------------------------------------------------------------------------
module sblur_ctrl import sblur_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_accept,
    input  logic                  i_action,
    input  t_pix                  i_pix,
    output logic [COL_W-1:0]      o_col,
    output logic [LINE_SEL_W-1:0] o_line_sel,
    output logic                  o_line_we,
    output t_pix                  o_pix,
    output t_item_ctrl            o_ctrl
);

    localparam logic [OUT_CNT_W-1:0] TOTAL_RESET = OUT_CNT_W'(WIDTH_RESET * HEIGHT_RESET);

    function automatic logic [CFG_W-1:0] clamp_width(input logic [CFG_W-1:0] raw);
        logic [CFG_W-1:0] v;
        v = raw;
        if (raw < CFG_W'(WIDTH_MIN)) v = CFG_W'(WIDTH_MIN);
        if (raw > CFG_W'(WIDTH_EFF_MAX)) v = CFG_W'(WIDTH_EFF_MAX);
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] clamp_height(input logic [CFG_W-1:0] raw);
        return (raw < CFG_W'(HEIGHT_MIN)) ? CFG_W'(HEIGHT_MIN) : raw;
    endfunction

    logic [CFG_W-1:0]     r_width;
    logic [CFG_W-1:0]     r_height;
    logic [OUT_CNT_W-1:0] r_total;
    logic [COL_W-1:0]     r_col;
    logic [ROW_W-1:0]     r_row;
    logic [OUT_CNT_W-1:0] r_out_cnt;

    logic [CFG_W-1:0]     w_sel;
    logic [CFG_W-1:0]     h_sel;
    logic [OUT_CNT_W-1:0] n_total;

    logic [COL_W-1:0]     c0;
    logic [ROW_W-1:0]     r0;
    logic [OUT_CNT_W-1:0] o0;
    logic [OUT_CNT_W-1:0] o1;
    logic [COLX_W-1:0]    c1x;
    logic                 emit;
    logic                 line_active;
    logic [COL_W-1:0]     n_col;
    logic [ROW_W-1:0]     n_row;
    logic [OUT_CNT_W-1:0] n_out_cnt;

    // frame size product for the new register values
    always_comb begin
        w_sel   = (i_cfg_idx == CFG_FRAME_WIDTH)  ? clamp_width(i_cfg_data)  : r_width;
        h_sel   = (i_cfg_idx == CFG_FRAME_HEIGHT) ? clamp_height(i_cfg_data) : r_height;
        n_total = OUT_CNT_W'(w_sel) * OUT_CNT_W'(h_sel);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(WIDTH_RESET);
            r_height <= CFG_W'(HEIGHT_RESET);
            r_total  <= TOTAL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH: begin
                    r_width <= w_sel;
                    r_total <= n_total;
                end
                CFG_FRAME_HEIGHT: begin
                    r_height <= h_sel;
                    r_total  <= n_total;
                end
                default: begin
                end
            endcase
        end
    end

    // position of this request and the position after it
    always_comb begin
        c0  = r_col;
        r0  = r_row;
        o0  = r_out_cnt;
        c1x = '0;
        if (COLX_W'(r_col) >= COLX_W'(r_width)) begin
            c0 = '0;
            r0 = r_row + ROW_W'(1);
        end
        if (r_out_cnt >= r_total || r0 > ROW_W'(r_height) + ROW_W'(KERNEL_HALF)) begin
            c0 = '0;
            r0 = '0;
            o0 = '0;
        end

        emit = (r0 > ROW_W'(KERNEL_HALF))
            || (r0 == ROW_W'(KERNEL_HALF) && c0 >= COL_W'(KERNEL_HALF));
        o1 = o0 + OUT_CNT_W'(emit);

        if (o1 >= r_total) begin
            n_col     = '0;
            n_row     = '0;
            n_out_cnt = '0;
        end else begin
            n_out_cnt = o1;
            c1x       = COLX_W'(c0) + COLX_W'(1);
            if (c1x >= COLX_W'(r_width)) begin
                n_col = '0;
                n_row = r0 + ROW_W'(1);
            end else begin
                n_col = c1x[COL_W-1:0];
                n_row = r0;
            end
        end
    end

    // stream position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_out_cnt <= '0;
        end else if (i_accept) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_out_cnt <= n_out_cnt;
        end
    end

    // line buffer access and request control
    always_comb begin
        line_active      = r0 < ROW_W'(r_height);
        o_col            = c0;
        o_line_sel       = r0[LINE_SEL_W-1:0];
        o_line_we        = i_accept && line_active;
        o_pix            = (line_active && i_action == ACT_PIXEL) ? i_pix : '0;
        o_ctrl.vert_en   = (r0 >= ROW_W'(NUM_LINES)) && line_active;
        o_ctrl.center_en = (r0 >= ROW_W'(KERNEL_HALF))
                        && (r0 <= ROW_W'(r_height) + ROW_W'(KERNEL_HALF - 1));
        o_ctrl.emit      = emit;
        o_ctrl.border    = (c0 < COL_W'(2 * KERNEL_HALF))
                        || (r0 < ROW_W'(2 * KERNEL_HALF)) || !line_active;
        o_ctrl.eof       = emit && (o0 + OUT_CNT_W'(1) == r_total);
    end

endmodule

// File: rtl/sblur_lines.sv
// ----------------------------------------------------------------------------
// sblur_lines
// four row buffers, one per row modulo four, read at the current column
// ----------------------------------------------------------------------------
module sblur_lines import sblur_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [COL_W-1:0]      i_col,
    input  logic [LINE_SEL_W-1:0] i_line_sel,
    input  logic                  i_we,
    input  t_pix                  i_wdata,
    output t_pix                  o_rows [NUM_LINES]
);

    t_pix                  r_mem [NUM_LINES][MAX_WIDTH];
    t_pix                  r_rd  [NUM_LINES];
    logic [LINE_SEL_W-1:0] r_sel;

    // one buffer per row phase; read returns the old entry on a same-address write
    for (genvar g = 0; g < NUM_LINES; g++) begin : g_bank
        always_ff @(posedge i_clk) begin
            if (i_we && i_line_sel == LINE_SEL_W'(g)) begin
                r_mem[g][i_col] <= i_wdata;
            end
            if (i_rd_en) begin
                r_rd[g] <= r_mem[g][i_col];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_sel <= i_line_sel;
        end
    end

    // rotate so index 0 is four rows back and the last index is the previous row
    always_comb begin
        for (int k = 0; k < NUM_LINES; k++) begin
            o_rows[k] = r_rd[r_sel + LINE_SEL_W'(k)];
        end
    end

endmodule

// File: rtl/sblur_filter.sv
// ----------------------------------------------------------------------------
// sblur_filter
// vertical pass into a tap line, horizontal pass, border select, output reg
// ----------------------------------------------------------------------------
module sblur_filter import sblur_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_pix       i_pix,
    input  t_item_ctrl i_ctrl,
    input  t_pix       i_rows [NUM_LINES],
    output logic       o_free,
    output logic       o_valid,
    input  logic       i_ready,
    output t_pix       o_pix,
    output logic       o_eof
);

    logic       r_b_valid;
    t_pix       r_b_pix;
    t_item_ctrl r_b_ctrl;

    t_pix       r_taps   [KERNEL_TAPS];
    t_pix       r_center [CENTER_DEPTH];

    logic       r_c_valid;
    logic       r_c_border;
    logic       r_c_eof;

    logic       r_o_valid;
    t_pix       r_o_pix;
    logic       r_o_eof;

    logic       out_free;
    logic       c_free;
    logic       c_move;
    logic       b_move;
    t_pix       vert;
    t_pix       center;
    t_pix       res;

    // stage handshake
    assign out_free = !r_o_valid || i_ready;
    assign c_free   = !r_c_valid || out_free;
    assign c_move   = r_c_valid && out_free;
    assign b_move   = r_b_valid && c_free;
    assign o_free   = !r_b_valid || c_free;

    // request register in front of the vertical pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_load) begin
            r_b_valid <= 1'b1;
        end else if (b_move) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_b_pix  <= i_pix;
            r_b_ctrl <= i_ctrl;
        end
    end

    // vertical pass and unfiltered center pixel
    always_comb begin
        vert   = r_b_ctrl.vert_en
               ? mix5_pix(i_rows[0], i_rows[1], i_rows[2], i_rows[3], r_b_pix) : '0;
        center = r_b_ctrl.center_en ? i_rows[KERNEL_HALF] : '0;
    end

    // tap line and center delay shift once per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KERNEL_TAPS; k++) begin
                r_taps[k] <= '0;
            end
            for (int k = 0; k < CENTER_DEPTH; k++) begin
                r_center[k] <= '0;
            end
        end else if (b_move) begin
            for (int k = 0; k < KERNEL_TAPS - 1; k++) begin
                r_taps[k] <= r_taps[k + 1];
            end
            r_taps[KERNEL_TAPS - 1] <= vert;
            for (int k = CENTER_DEPTH - 1; k > 0; k--) begin
                r_center[k] <= r_center[k - 1];
            end
            r_center[0] <= center;
        end
    end

    // horizontal stage holds only requests that produce a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (b_move) begin
            r_c_valid <= r_b_ctrl.emit;
        end else if (c_move) begin
            r_c_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_c_border <= r_b_ctrl.border;
            r_c_eof    <= r_b_ctrl.eof;
        end
    end

    // horizontal pass or border pass-through
    assign res = r_c_border ? r_center[CENTER_DEPTH - 1]
               : mix5_pix(r_taps[0], r_taps[1], r_taps[2], r_taps[3], r_taps[4]);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (c_move) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_move) begin
            r_o_pix <= res;
            r_o_eof <= r_c_eof;
        end
    end

    assign o_valid = r_o_valid;
    assign o_pix   = r_o_pix;
    assign o_eof   = r_o_eof;

endmodule

// File: rtl/separable_blur_5x5_stream.sv
// ----------------------------------------------------------------------------
// separable_blur_5x5_stream
// 5x5 separable 1,2,4,2,1 blur over BGR pixels in raster order.
// i_pix takes one request per pixel (action 0) or flush (action 1); o_pix
// returns blurred pixels, with the two-pixel frame border passed through.
// Frame size comes from the write port (index 0 width, index 1 height); the
// user must write it only while the block is idle, not enforced by the
// block. Throughput is one request per cycle; when the receiver stalls, the
// output holds and requests are still taken until the internal stages fill;
// i_pix.ready then drops. A result passes the request, horizontal and
// output registers; the request that produces it lies two rows and two
// columns past the pixel, so a frame needs 2*width+2 flush requests after
// its last pixel, and the last result carries end_of_frame. Four row
// buffers of MAX_WIDTH pixels are read in the cycle of each request,
// written for rows in the frame; they are not cleared at reset and need no
// clearing pass. Reset clears the counters, taps and frame size to 640x480.
// ----------------------------------------------------------------------------
module separable_blur_5x5_stream import sblur_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    sblur_in_if.sink             i_pix,
    sblur_out_if.source          o_pix
);

    logic                  free;
    logic                  accept;
    t_pix                  in_pix;
    logic [COL_W-1:0]      col;
    logic [LINE_SEL_W-1:0] line_sel;
    logic                  line_we;
    t_pix                  line_pix;
    t_item_ctrl            item_ctrl;
    t_pix                  rows [NUM_LINES];
    t_pix                  out_pix;
    logic                  out_eof;

    // input handshake
    assign i_pix.ready = i_rst_n && free;
    assign accept      = i_pix.valid && i_pix.ready;

    always_comb begin
        in_pix.red   = i_pix.in_red;
        in_pix.green = i_pix.in_green;
        in_pix.blue  = i_pix.in_blue;
    end

    sblur_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_action   (i_pix.action),
        .i_pix      (in_pix),
        .o_col      (col),
        .o_line_sel (line_sel),
        .o_line_we  (line_we),
        .o_pix      (line_pix),
        .o_ctrl     (item_ctrl)
    );

    sblur_lines u_lines (
        .i_clk      (i_clk),
        .i_rd_en    (accept),
        .i_col      (col),
        .i_line_sel (line_sel),
        .i_we       (line_we),
        .i_wdata    (line_pix),
        .o_rows     (rows)
    );

    sblur_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_pix   (line_pix),
        .i_ctrl  (item_ctrl),
        .i_rows  (rows),
        .o_free  (free),
        .o_valid (o_pix.valid),
        .i_ready (o_pix.ready),
        .o_pix   (out_pix),
        .o_eof   (out_eof)
    );

    // result channel payload
    assign o_pix.out_blue     = out_pix.blue;
    assign o_pix.out_green    = out_pix.green;
    assign o_pix.out_red      = out_pix.red;
    assign o_pix.end_of_frame = out_eof;

endmodule

// File: rtl/sblur_checker.sv
// ----------------------------------------------------------------------------
// sblur_checker
// port-level checks on the blur top level, attached by bind
// ----------------------------------------------------------------------------
`include "separable_blur_5x5_stream_assert.svh"

module sblur_checker import sblur_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CHAN_W-1:0] i_out_blue,
    input logic [CHAN_W-1:0] i_out_green,
    input logic [CHAN_W-1:0] i_out_red,
    input logic              i_out_eof
);

    logic                out_stall;
    logic                in_accept;
    logic [3*CHAN_W:0]   out_word;

    // handshake terms and the full result word
    assign out_stall = i_out_valid && !i_out_ready;
    assign in_accept = i_in_valid && i_in_ready;
    assign out_word  = {i_out_eof, i_out_red, i_out_green, i_out_blue};

    // a stalled result holds its payload
    `SBLUR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(out_word))

    // a fresh result follows a request through three register stages
    `SBLUR_ASSERT_IMPLY(a_out_latency, i_clk, i_rst_n, $rose(i_out_valid), $past(in_accept, 3))

    // input backpressure only when the output is stalled
    `SBLUR_ASSERT_IMPLY(a_ready_stall, i_clk, i_rst_n, !i_in_ready, out_stall)

endmodule

bind separable_blur_5x5_stream sblur_checker u_sblur_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_blue  (o_pix.out_blue),
    .i_out_green (o_pix.out_green),
    .i_out_red   (o_pix.out_red),
    .i_out_eof   (o_pix.end_of_frame)
);

// File: dv/separable_blur_5x5_stream_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// separable_blur_5x5_stream_tb
// Streams whole BGR frames through the 5x5 blur and compares every result
// pixel and its frame-end flag with a cycle-free predictor of the filter.
// Frame sizes change only between frames; covers clamped sizes, ignored
// register indexes, in-frame flushes, stray pixels in the drain, wide
// rows and a tall frame, under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module separable_blur_5x5_stream_tb;
    import sblur_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

    localparam int unsigned RANDOM_ITEMS  = 700;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 3_000_000;
    localparam int unsigned DIRECTED_SIDE = 5;
    localparam int unsigned WIDE_SIDE     = 64;

    typedef struct packed {
        logic eof;
        t_pix px;
    } t_blur_result;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE_STALL,
        SINK_LONG_STALL
    } t_sink_mode;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]   cfg_data;

    sblur_in_if  pix_in ();
    sblur_out_if pix_out ();

    separable_blur_5x5_stream i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_in),
        .o_pix      (pix_out)
    );

    // predictor state
    t_pix        row_history [4 * MAX_WIDTH];
    t_pix        vert_taps [KERNEL_TAPS] = '{default: '0};
    t_pix        center_dly [3] = '{default: '0};
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    int unsigned emitted = 0;
    int unsigned cfg_width = WIDTH_RESET;
    int unsigned cfg_height = HEIGHT_RESET;

    t_blur_result blurred_pending_q [$];
    int unsigned  mismatches = 0;
    int unsigned  cycle_count = 0;
    int unsigned  burst_left = 0;

    t_sink_mode  sink_mode = SINK_OPEN;
    int unsigned sink_mode_left = 0;
    int unsigned sink_run = 0;
    logic        sink_hold = 1'b0;

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("separable_blur_5x5_stream_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic int unsigned eff_width();
        if (cfg_width < WIDTH_MIN) return WIDTH_MIN;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        if (cfg_height < HEIGHT_MIN) return HEIGHT_MIN;
        return cfg_height;
    endfunction

    function automatic int unsigned line_slot(input int unsigned row, input int unsigned col);
        return (row % 4) * MAX_WIDTH + col;
    endfunction

    // 1,2,4,2,1 over ten, truncated, one channel
    function automatic logic [7:0] weigh5(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c, input logic [7:0] d,
                                          input logic [7:0] e);
        int unsigned s;
        s = int'(a) + 2 * int'(b) + 4 * int'(c) + 2 * int'(d) + int'(e);
        return 8'(s / 10);
    endfunction

    function automatic t_pix blend5(input t_pix a, input t_pix b, input t_pix c,
                                    input t_pix d, input t_pix e);
        t_pix r;
        r.blue  = weigh5(a.blue, b.blue, c.blue, d.blue, e.blue);
        r.green = weigh5(a.green, b.green, c.green, d.green, e.green);
        r.red   = weigh5(a.red, b.red, c.red, d.red, e.red);
        return r;
    endfunction

    // advance the stream by one request; returns 1 when it yields a result
    function automatic bit next_blurred_pixel(input logic act, input t_pix src,
                                              output t_blur_result res);
        int unsigned w, h, total, r, c, orow, ocol;
        t_pix px, vert, ctr;
        bit hit;
        w = eff_width();
        h = eff_height();
        total = w * h;
        hit = 1'b0;
        res = '0;

        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (emitted >= total || row_pos > h + 2) begin
            col_pos = 0;
            row_pos = 0;
            emitted = 0;
        end
        r = row_pos;
        c = col_pos;

        // flushes inside the frame count as black, anything in the drain is dropped
        px = (r < h && act == ACT_PIXEL) ? src : '0;
        vert = '0;
        if (r >= 4 && r < h)
            vert = blend5(row_history[line_slot(r - 4, c)], row_history[line_slot(r - 3, c)],
                          row_history[line_slot(r - 2, c)], row_history[line_slot(r - 1, c)],
                          px);
        ctr = (r >= 2 && r <= h + 1) ? row_history[line_slot(r - 2, c)] : '0;
        if (r < h)
            row_history[line_slot(r, c)] = px;

        for (int k = 0; k < KERNEL_TAPS - 1; k++)
            vert_taps[k] = vert_taps[k + 1];
        vert_taps[KERNEL_TAPS - 1] = vert;
        center_dly[2] = center_dly[1];
        center_dly[1] = center_dly[0];
        center_dly[0] = ctr;

        // result for the pixel two rows and two columns back
        if (r > 2 || (r == 2 && c >= 2)) begin
            if (c >= 2) begin
                orow = r - 2;
                ocol = c - 2;
            end else begin
                orow = r - 3;
                ocol = c + w - 2;
            end
            if (orow < 2 || orow >= h - 2 || ocol < 2 || ocol >= w - 2)
                res.px = center_dly[2];
            else
                res.px = blend5(vert_taps[0], vert_taps[1], vert_taps[2], vert_taps[3],
                                vert_taps[4]);
            res.eof = (emitted + 1 == total);
            emitted++;
            hit = 1'b1;
        end

        if (emitted >= total) begin
            col_pos = 0;
            row_pos = 0;
            emitted = 0;
        end else begin
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
        end
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // scoreboard
    // ------------------------------------------------------------------
    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : score_pixels
        t_pix         src;
        t_blur_result want;
        if (i_rst_n) begin
            // accepted request: predict its result, if any
            if (pix_in.valid && pix_in.ready) begin
                src.blue  = pix_in.in_blue;
                src.green = pix_in.in_green;
                src.red   = pix_in.in_red;
                if (next_blurred_pixel(pix_in.action, src, want))
                    blurred_pending_q.push_back(want);
            end
            // accepted result: compare with the oldest prediction
            if (pix_out.valid && pix_out.ready) begin
                if (blurred_pending_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none actual b=%0d g=%0d r=%0d eof=%0d",
                             $time, pix_out.out_blue, pix_out.out_green, pix_out.out_red,
                             pix_out.end_of_frame);
                end else begin
                    want = blurred_pending_q.pop_front();
                    check_field("blue", want.px.blue, pix_out.out_blue);
                    check_field("green", want.px.green, pix_out.out_green);
                    check_field("red", want.px.red, pix_out.out_red);
                    check_field("end_of_frame", want.eof, pix_out.end_of_frame);
                end
            end
        end
    end

    // receiver stalls, switching between a few patterns
    always @(negedge i_clk) begin
        if (sink_mode_left == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 3));
            sink_mode_left = $urandom_range(50, 300);
        end
        sink_mode_left--;
        case (sink_mode)
            SINK_OPEN: begin
                pix_out.ready <= 1'b1;
            end
            SINK_COIN: begin
                pix_out.ready <= ($urandom_range(0, 1) == 1);
            end
            SINK_SPARSE_STALL: begin
                pix_out.ready <= ($urandom_range(0, 7) != 0);
            end
            default: begin
                if (sink_run == 0) begin
                    sink_hold = !sink_hold;
                    sink_run = sink_hold ? $urandom_range(1, 4) : $urandom_range(1, 12);
                end
                sink_run--;
                pix_out.ready <= sink_hold;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_FRAME_WIDTH:  cfg_width = 32'(value);
            CFG_FRAME_HEIGHT: cfg_height = 32'(value);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_item(input logic act, input t_pix px);
        @(negedge i_clk);
        pix_in.valid    <= 1'b1;
        pix_in.action   <= act;
        pix_in.in_blue  <= px.blue;
        pix_in.in_green <= px.green;
        pix_in.in_red   <= px.red;
        do @(posedge i_clk); while (!pix_in.ready);
    endtask

    // bursts of requests with random gaps between them
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                pix_in.valid    <= 1'b0;
                pix_in.action   <= 1'($urandom_range(0, 1));
                pix_in.in_blue  <= 8'($urandom_range(0, 255));
                pix_in.in_green <= 8'($urandom_range(0, 255));
                pix_in.in_red   <= 8'($urandom_range(0, 255));
            end
        end
        burst_left--;
    endtask

    // stop sending until every predicted result is back
    task automatic drain_results(input int unsigned extra);
        @(negedge i_clk);
        pix_in.valid <= 1'b0;
        while (blurred_pending_q.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one complete frame plus its drain, random content
    task automatic run_frame(input int unsigned flush_pct, input int unsigned stray_pct,
                             output int unsigned sent);
        int unsigned w, h, pixels;
        t_pix px;
        logic act;
        w = eff_width();
        h = eff_height();
        pixels = w * h;
        sent = pixels + 2 * w + 2;
        for (int unsigned k = 0; k < sent; k++) begin
            pace_sender();
            if ($urandom_range(0, 499) == 0)
                drain_results(0);
            if (k < pixels)
                act = ($urandom_range(0, 99) < flush_pct) ? ACT_FLUSH : ACT_PIXEL;
            else
                act = ($urandom_range(0, 99) < stray_pct) ? ACT_PIXEL : ACT_FLUSH;
            px.blue  = rand_chan();
            px.green = rand_chan();
            px.red   = rand_chan();
            send_item(act, px);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // smallest frame from zero sizes, fixed pattern with saturated channels
    task automatic test_directed_frame();
        int unsigned x, y, total;
        t_pix px;
        logic act;
        write_reg(CFG_FRAME_WIDTH, '0);
        write_reg(CFG_FRAME_HEIGHT, '0);
        total = DIRECTED_SIDE * DIRECTED_SIDE + 2 * DIRECTED_SIDE + 2;
        for (int unsigned i = 0; i < total; i++) begin
            x = i % DIRECTED_SIDE;
            y = i / DIRECTED_SIDE;
            px.blue  = 8'hFF;
            px.green = ((x + y) % 2 == 1) ? 8'hFF : 8'h00;
            px.red   = (x < 2) ? 8'hA5 : 8'h5A;
            act = ACT_PIXEL;
            // flush on the center pixel reads as black
            if (i == DIRECTED_SIDE * DIRECTED_SIDE / 2)
                act = ACT_FLUSH;
            // drain: flushes, one real pixel that must be dropped
            if (i >= DIRECTED_SIDE * DIRECTED_SIDE)
                act = (i == DIRECTED_SIDE * DIRECTED_SIDE + 4) ? ACT_PIXEL : ACT_FLUSH;
            // hold off mid-frame until all results are back
            if (i == 4 * DIRECTED_SIDE)
                drain_results(0);
            pace_sender();
            send_item(act, px);
        end
    endtask

    // writes to unused indexes must leave the frame size alone
    task automatic test_spare_indexes();
        int unsigned sent;
        drain_results(SETTLE_CYCLES);
        write_reg(CFG_IDX_SPARE_A, '1);
        write_reg(CFG_IDX_SPARE_B, '1);
        run_frame(10, 20, sent);
    endtask

    // mostly small random frames, sizes below the minimum included
    task automatic test_random_frames();
        int unsigned total, sent;
        total = 0;
        while (total < RANDOM_ITEMS) begin
            if (total == 0 || $urandom_range(0, 2) != 0) begin
                drain_results(SETTLE_CYCLES);
                write_reg(CFG_FRAME_WIDTH, ($urandom_range(0, 3) == 0)
                          ? CFG_W'($urandom_range(15, 48)) : CFG_W'($urandom_range(0, 12)));
                write_reg(CFG_FRAME_HEIGHT, CFG_W'($urandom_range(0, 12)));
                if ($urandom_range(0, 3) == 0)
                    write_reg(($urandom_range(0, 1) == 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                              CFG_W'($urandom_range(0, 4095)));
            end
            run_frame($urandom_range(0, 10), $urandom_range(0, 30), sent);
            total += sent;
        end
    endtask

    // long rows over the shortest frame
    task automatic test_widest_rows();
        int unsigned sent;
        drain_results(SETTLE_CYCLES);
        write_reg(CFG_FRAME_WIDTH, CFG_W'(WIDE_SIDE));
        write_reg(CFG_FRAME_HEIGHT, '0);
        run_frame(2, 5, sent);
    endtask

    // many rows with the narrowest width
    task automatic test_tallest_frame();
        int unsigned sent;
        drain_results(SETTLE_CYCLES);
        write_reg(CFG_FRAME_WIDTH, CFG_W'(WIDTH_MIN));
        write_reg(CFG_FRAME_HEIGHT, CFG_W'(WIDE_SIDE));
        run_frame(2, 5, sent);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        pix_in.valid    = 1'b0;
        pix_in.action   = ACT_PIXEL;
        pix_in.in_blue  = '0;
        pix_in.in_green = '0;
        pix_in.in_red   = '0;
        pix_out.ready   = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_frame();
        test_spare_indexes();
        test_random_frames();
        test_widest_rows();
        test_tallest_frame();

        drain_results(SETTLE_CYCLES);
        if (mismatches == 0 && blurred_pending_q.size() == 0) begin
            $display("separable_blur_5x5_stream_tb OK");
        end else begin
            $display("separable_blur_5x5_stream_tb NOT OK");
        end
        $finish;
    end

endmodule
